// ===== rtl/core/pwm_ws_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM window scorer package
// Shared widths, codes and the character-to-base mapping.
// ----------------------------------------------------------------------------
package pwm_ws_pkg;

   localparam int MAX_WIDTH_DEF = 32;

   localparam int WEIGHT_W   = 16;
   localparam int SCORE_W    = 21;
   localparam int POS_W      = 20;
   localparam int CFG_W      = 6;
   localparam int CHAR_W     = 8;
   localparam int ROW_W      = 5;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0]      WIDTH_RESET     = 6'd8;
   localparam logic [CSR_ADDR_W-1:0] REG_MOTIF_WIDTH = 2'd0;
   localparam logic [POS_W-1:0]      COUNT_MAX       = '1;

   localparam logic [CHAR_W-1:0] CHAR_UC_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_LC_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_UC_C = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_LC_C = 8'h63;
   localparam logic [CHAR_W-1:0] CHAR_UC_G = 8'h47;
   localparam logic [CHAR_W-1:0] CHAR_LC_G = 8'h67;
   localparam logic [CHAR_W-1:0] CHAR_UC_T = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_LC_T = 8'h74;

   typedef enum logic [1:0] {BASE_A, BASE_C, BASE_G, BASE_T} base_type;
   typedef enum logic {KIND_CHAR, KIND_WEIGHT} kind_type;

   function automatic base_type char_code(input logic [CHAR_W-1:0] ch);
      base_type code;
      case (ch)
         CHAR_UC_A, CHAR_LC_A: code = BASE_A;
         CHAR_UC_C, CHAR_LC_C: code = BASE_C;
         CHAR_UC_G, CHAR_LC_G: code = BASE_G;
         CHAR_UC_T, CHAR_LC_T: code = BASE_T;
         default:              code = BASE_A;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/core/pwm_ws_sum_tree.sv =====
// ----------------------------------------------------------------------------
// PWM window scorer sum tree
// Registered pairwise adder tree, one level per stage, each level loaded
// by its own enable.
// ----------------------------------------------------------------------------
module pwm_ws_sum_tree #(
   parameter int  MAX_WIDTH = pwm_ws_pkg::MAX_WIDTH_DEF,
   localparam int LEVELS    = $clog2(MAX_WIDTH),
   localparam int LANES     = 1 << LEVELS,
   localparam int SUM_W     = pwm_ws_pkg::WEIGHT_W + LEVELS
) (
   input  logic                                  clock,
   input  logic [LEVELS:0]                       load,
   input  logic signed [pwm_ws_pkg::WEIGHT_W-1:0] term [LANES],
   output logic signed [SUM_W-1:0]               total
);
   import pwm_ws_pkg::*;

   logic signed [SUM_W-1:0] node_ff [LEVELS+1][LANES];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         for (int i = 0; i < LANES; i++) begin
            node_ff[0][i] <= SUM_W'(term[i]);
         end
      end
      for (int l = 1; l <= LEVELS; l++) begin
         if (load[l]) begin
            for (int i = 0; i < (LANES >> l); i++) begin
               node_ff[l][i] <= node_ff[l-1][2*i] + node_ff[l-1][2*i+1];
            end
         end
      end
   end

   assign total = node_ff[LEVELS][0];

endmodule

// ===== rtl/core/pwm_window_scorer_unit.sv =====
// ----------------------------------------------------------------------------
// PWM window scorer unit
// Streaming position weight matrix motif scan over DNA characters.
// ----------------------------------------------------------------------------
// Request beats carry either a weight write (row, base, Q7.8 value) or one
// sequence character; seq_start begins a new sequence. Once the window of
// the configured width is full, every character beat yields one response
// beat: the Q12.8 window score and the window start position (saturating).
// Weight writes and short-window characters yield no response.
// Throughput is one request beat per cycle while responses are taken. A
// scored character reaches rsp_valid through the aligned window register,
// which loads at the accept edge, then the weight select register, one
// register per adder tree level and the saturating output register.
// Every stage holds its beat while the next one is full, so a stalled
// response only blocks requests once the whole pipeline has filled.
// The window width register sits at byte address 0 of the CSR port. The user
// must write it only while the unit is idle; the unit does not enforce this.
// Reset clears the window, the count and the pipeline and sets the width to
// 8; the weight table is not cleared and must be written before scoring.
// ----------------------------------------------------------------------------
module pwm_window_scorer_unit #(
   parameter int MAX_WIDTH = pwm_ws_pkg::MAX_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_kind,
   input  logic [pwm_ws_pkg::CHAR_W-1:0]          req_base_char,
   input  logic                                   req_seq_start,
   input  logic [pwm_ws_pkg::ROW_W-1:0]           req_weight_row,
   input  logic [1:0]                             req_weight_base,
   input  logic signed [pwm_ws_pkg::WEIGHT_W-1:0] req_weight_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [pwm_ws_pkg::SCORE_W-1:0]  rsp_score,
   output logic [pwm_ws_pkg::POS_W-1:0]           rsp_position,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [pwm_ws_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pwm_ws_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pwm_ws_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                   csr_pready
);
   import pwm_ws_pkg::*;

   localparam int LEVELS = $clog2(MAX_WIDTH);
   localparam int LANES  = 1 << LEVELS;
   localparam int SUM_W  = WEIGHT_W + LEVELS;
   localparam int NSTG   = LEVELS + 3;
   localparam int LAST   = NSTG - 1;
   localparam int IDX_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = ((WID_W > CFG_W) ? WID_W : CFG_W) + 1;
   localparam int ROW_CMP_W = ROW_W + 2;
   localparam int EXT_W  = (SUM_W > SCORE_W) ? SUM_W : SCORE_W + 1;
   localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(2**(SCORE_W-1) - 1);
   localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(-(2**(SCORE_W-1)));

   logic [CFG_W-1:0]          width_ff;
   logic [WID_W-1:0]          eff_w;
   logic [IDX_W-1:0]          shift_amt;
   logic [1:0]                win_ff [MAX_WIDTH];
   logic [1:0]                win_in [MAX_WIDTH];
   logic [1:0]                align_ff [MAX_WIDTH];
   logic [1:0]                align_in [MAX_WIDTH];
   logic [POS_W-1:0]          count_ff;
   logic [POS_W-1:0]          count_in;
   logic [POS_W-1:0]          count_base;
   logic [POS_W-1:0]          pos_ff [NSTG];
   logic [POS_W-1:0]          pos_in;
   logic [NSTG-1:0]           vld_ff;
   logic [NSTG-1:0]           load;
   logic                      req_beat;
   logic                      char_beat;
   logic                      weight_beat;
   logic                      scored;
   logic                      row_ok;
   logic [IDX_W-1:0]          weight_idx;
   logic signed [WEIGHT_W-1:0] weight_ff [MAX_WIDTH][4];
   logic signed [WEIGHT_W-1:0] term [LANES];
   logic signed [SUM_W-1:0]   total;
   logic signed [EXT_W-1:0]   total_ext;
   logic signed [SCORE_W-1:0] score_in;
   logic signed [SCORE_W-1:0] score_ff;
   logic                      csr_wr;

   // CSR
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DATA_W'(width_ff);

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(width_ff);
      end
   end

   assign shift_amt = IDX_W'(WID_W'(MAX_WIDTH) - eff_w);

   // request side
   assign req_beat    = req_valid && req_ready;
   assign char_beat   = req_beat && (req_kind == KIND_CHAR);
   assign weight_beat = req_beat && (req_kind == KIND_WEIGHT);
   assign row_ok      = ROW_CMP_W'(req_weight_row) < ROW_CMP_W'(MAX_WIDTH);
   assign weight_idx  = IDX_W'(req_weight_row);

   assign count_base = req_seq_start ? '0 : count_ff;
   assign count_in   = (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;
   assign scored     = count_in >= POS_W'(eff_w);
   assign pos_in     = count_in - POS_W'(eff_w);

   always_comb begin
      for (int i = 0; i < MAX_WIDTH - 1; i++) begin
         win_in[i] = req_seq_start ? 2'b00 : win_ff[i+1];
      end
      win_in[MAX_WIDTH-1] = char_code(req_base_char);
   end

   // oldest base of the window lands in lane 0
   always_comb begin
      logic [IDX_W:0] idx;
      for (int j = 0; j < MAX_WIDTH; j++) begin
         idx = (IDX_W+1)'(j) + (IDX_W+1)'(shift_amt);
         if (idx < (IDX_W+1)'(MAX_WIDTH)) begin
            align_in[j] = win_in[idx[IDX_W-1:0]];
         end else begin
            align_in[j] = 2'b00;
         end
      end
   end

   // pipeline flow: a stage loads when empty or when it drains
   always_comb begin
      logic take;
      take = rsp_ready;
      for (int k = LAST; k >= 0; k--) begin
         load[k] = !vld_ff[k] || take;
         take    = load[k];
      end
   end

   assign req_ready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         count_ff <= '0;
         vld_ff   <= '0;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            win_ff[i] <= 2'b00;
         end
      end else begin
         if (csr_wr && (csr_paddr == REG_MOTIF_WIDTH)) begin
            width_ff <= csr_pwdata[CFG_W-1:0];
         end
         if (char_beat) begin
            count_ff <= count_in;
            win_ff   <= win_in;
         end
         if (load[0]) begin
            vld_ff[0] <= char_beat && scored;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (load[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         align_ff  <= align_in;
         pos_ff[0] <= pos_in;
      end
      for (int k = 1; k < NSTG; k++) begin
         if (load[k]) begin
            pos_ff[k] <= pos_ff[k-1];
         end
      end
      if (load[LAST]) begin
         score_ff <= score_in;
      end
      if (weight_beat && row_ok) begin
         weight_ff[weight_idx][req_weight_base] <= req_weight_value;
      end
   end

   // weight select, columns past the width contribute zero
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         term[j] = '0;
      end
      for (int j = 0; j < MAX_WIDTH; j++) begin
         if (j < int'(eff_w)) begin
            term[j] = weight_ff[j][align_ff[j]];
         end
      end
   end

   pwm_ws_sum_tree #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_sum_tree (
      .clock (clock),
      .load  (load[LEVELS+1:1]),
      .term  (term),
      .total (total)
   );

   always_comb begin
      total_ext = EXT_W'(total);
      if (total_ext > SAT_HI) begin
         score_in = SCORE_W'(SAT_HI);
      end else if (total_ext < SAT_LO) begin
         score_in = SCORE_W'(SAT_LO);
      end else begin
         score_in = SCORE_W'(total_ext);
      end
   end

   assign rsp_valid    = vld_ff[LAST];
   assign rsp_score    = score_ff;
   assign rsp_position = pos_ff[LAST];

endmodule

// ===== rtl/core/pwm_ws_checker.sv =====
// ----------------------------------------------------------------------------
// PWM window scorer checker
// Port-level checks on the scorer unit, bound to the scorer unit module.
// ----------------------------------------------------------------------------
module pwm_ws_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [pwm_ws_pkg::SCORE_W-1:0]  rsp_score,
   input logic [pwm_ws_pkg::POS_W-1:0]           rsp_position,
   input logic [pwm_ws_pkg::CSR_DATA_W-1:0]      csr_prdata
);
   import pwm_ws_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_reset_width: assert property (@(posedge clock)
      reset |=> (csr_prdata == CSR_DATA_W'(WIDTH_RESET)))
      else $error("width register not at reset value");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position != COUNT_MAX))
      else $error("window start beyond saturated count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_score) && $stable(rsp_position)))
      else $error("stalled response beat changed");

endmodule

bind pwm_window_scorer_unit pwm_ws_checker u_pwm_ws_checker (.*);
